### design/assert_macros.svh
// Assertion macros shared by the vector clock unit modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

### design/vcu_pkg.sv
// Package for the vector clock unit: codes, field widths and the command
// and status types between controller and datapath. No dependencies.
package vcu_pkg;

    localparam int OP_W        = 2;
    localparam int FIELD_IDX_W = 3;
    localparam int VALUE_W     = 32;
    localparam int REL_W       = 2;
    localparam int CNT_W       = 4;
    localparam int RUN_LIMIT   = 8;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (FIELD_IDX_W + VALUE_W + REL_W);

    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_INDEX        = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_PROCESSES = 1'd1;

    localparam logic [FIELD_IDX_W-1:0] OWN_INDEX_RESET = 3'd0;
    localparam logic [CNT_W-1:0]       ACTIVE_RESET    = 4'd8;

    localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
    localparam logic [OP_W-1:0] OP_RECEIVE = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPARE = 2'd2;

    localparam logic KIND_ELEMENT  = 1'b0;
    localparam logic KIND_RELATION = 1'b1;

    localparam logic [REL_W-1:0] REL_EQUAL      = 2'd0;
    localparam logic [REL_W-1:0] REL_INCOMING   = 2'd1;
    localparam logic [REL_W-1:0] REL_STORED     = 2'd2;
    localparam logic [REL_W-1:0] REL_CONCURRENT = 2'd3;

    typedef struct packed {
        logic                   merge;
        logic                   compare;
        logic                   bump;
        logic                   load_elem;
        logic                   load_rel;
        logic [FIELD_IDX_W-1:0] emit_idx;
        logic                   emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic             out_free;
        logic [CNT_W-1:0] entries;
    } dp_status_t;

endpackage

### design/vcu_datapath.sv
// Datapath of the vector clock unit: configuration registers, counter
// vector, compare flags and the result register. Depends on vcu_pkg.
`include "assert_macros.svh"

module vcu_datapath #(
    parameter int MAX_PROCESSES = 8,
    parameter int COUNTER_BITS  = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [vcu_pkg::CFG_ADDR_W-1:0]     cfg_wr_index,
    input  logic [vcu_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic [vcu_pkg::FIELD_IDX_W-1:0]    elem_index,
    input  logic [vcu_pkg::VALUE_W-1:0]        elem_value,
    input  logic                               elem_last,
    input  vcu_pkg::dp_cmd_t                   cmd,
    output vcu_pkg::dp_status_t                status,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vcu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import vcu_pkg::*;

    localparam int DEPTH  = (MAX_PROCESSES < RUN_LIMIT) ? MAX_PROCESSES : RUN_LIMIT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0]        DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX   = '1;

    logic [FIELD_IDX_W-1:0]  own_index_reg;
    logic [CNT_W-1:0]        active_reg;
    logic [COUNTER_BITS-1:0] vec_reg [DEPTH];
    logic                    inc_seen_reg;
    logic                    sto_seen_reg;
    logic [REL_W-1:0]        rel_reg;

    logic                    out_valid_reg;
    logic                    out_kind_reg;
    logic [FIELD_IDX_W-1:0]  out_index_reg;
    logic [VALUE_W-1:0]      out_value_reg;
    logic                    out_last_reg;
    logic [REL_W-1:0]        out_rel_reg;

    logic [CNT_W-1:0]        entries;
    logic                    elem_in_range;
    logic                    own_in_range;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COUNTER_BITS-1:0] rd_val;
    logic [COUNTER_BITS-1:0] in_val;
    logic                    in_greater;
    logic                    in_less;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [COUNTER_BITS-1:0] wr_data;
    logic                    inc_now;
    logic                    sto_now;
    logic [REL_W-1:0]        rel_now;

    always_comb begin
        if (active_reg == '0) begin
            entries = CNT_W'(1);
        end else if (active_reg > DEPTH_CNT) begin
            entries = DEPTH_CNT;
        end else begin
            entries = active_reg;
        end
    end

    assign elem_in_range = CNT_W'(elem_index) < entries;
    assign own_in_range  = CNT_W'(own_index_reg) < entries;
    assign in_val        = COUNTER_BITS'(elem_value);

    always_comb begin
        if (cmd.bump) begin
            rd_addr = own_index_reg[ADDR_W-1:0];
        end else if (cmd.load_elem) begin
            rd_addr = cmd.emit_idx[ADDR_W-1:0];
        end else begin
            rd_addr = elem_index[ADDR_W-1:0];
        end
    end

    assign rd_val     = vec_reg[rd_addr];
    assign in_greater = elem_in_range && (in_val > rd_val);
    assign in_less    = elem_in_range && (in_val < rd_val);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_data = rd_val;
        if (cmd.bump) begin
            wr_en   = own_in_range && (rd_val != CNT_MAX);
            wr_data = rd_val + COUNTER_BITS'(1);
        end else if (cmd.merge) begin
            wr_en   = in_greater;
            wr_data = in_val;
        end
    end

    assign inc_now = inc_seen_reg || in_greater;
    assign sto_now = sto_seen_reg || in_less;

    always_comb begin
        if (inc_now && sto_now) begin
            rel_now = REL_CONCURRENT;
        end else if (inc_now) begin
            rel_now = REL_INCOMING;
        end else if (sto_now) begin
            rel_now = REL_STORED;
        end else begin
            rel_now = REL_EQUAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_index_reg <= OWN_INDEX_RESET;
            active_reg    <= ACTIVE_RESET;
            vec_reg       <= '{default: '0};
            inc_seen_reg  <= 1'b0;
            sto_seen_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_OWN_INDEX:        own_index_reg <= cfg_wr_data[FIELD_IDX_W-1:0];
                    CFG_ACTIVE_PROCESSES: active_reg    <= cfg_wr_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (wr_en) begin
                vec_reg[wr_addr] <= wr_data;
            end
            if (cmd.compare) begin
                if (elem_last) begin
                    inc_seen_reg <= 1'b0;
                    sto_seen_reg <= 1'b0;
                end else begin
                    inc_seen_reg <= inc_now;
                    sto_seen_reg <= sto_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare && elem_last) begin
            rel_reg <= rel_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_elem || cmd.load_rel) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_elem) begin
            out_kind_reg  <= KIND_ELEMENT;
            out_index_reg <= cmd.emit_idx;
            out_value_reg <= VALUE_W'(rd_val);
            out_last_reg  <= cmd.emit_last;
            out_rel_reg   <= REL_EQUAL;
        end else if (cmd.load_rel) begin
            out_kind_reg  <= KIND_RELATION;
            out_index_reg <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
            out_rel_reg   <= rel_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign status.entries  = entries;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_rel_reg, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

    `ASSERT_CLK(a_entries_range, aclk, aresetn, (entries != '0) && (entries <= DEPTH_CNT), "entry count out of range")
    `ASSERT_CLK(a_flags_cleared, aclk, aresetn, (cmd.compare && elem_last) |=> (!inc_seen_reg && !sto_seen_reg), "compare flags not cleared after last element")

endmodule

### design/vcu_ctrl.sv
// Controller of the vector clock unit: sequences receive, compare and send
// transactions and issues datapath commands. Depends on vcu_pkg.
`include "assert_macros.svh"

module vcu_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vcu_pkg::OP_W-1:0]     s_op,
    input  logic                         s_last,
    input  vcu_pkg::dp_status_t          status,
    output vcu_pkg::dp_cmd_t             cmd
);
    import vcu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND_BUMP,
        ST_RECV_BUMP,
        ST_EMIT,
        ST_REL
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [FIELD_IDX_W-1:0] emit_idx_reg;
    logic [FIELD_IDX_W-1:0] emit_idx_next;
    logic                   accept;
    logic                   emit_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign emit_last = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == status.entries;

    always_comb begin
        cmd.merge     = accept && (s_op == OP_RECEIVE);
        cmd.compare   = accept && (s_op == OP_COMPARE);
        cmd.bump      = (state_reg == ST_SEND_BUMP) || (state_reg == ST_RECV_BUMP);
        cmd.load_elem = (state_reg == ST_EMIT) && status.out_free;
        cmd.load_rel  = (state_reg == ST_REL) && status.out_free;
        cmd.emit_idx  = emit_idx_reg;
        cmd.emit_last = emit_last;
    end

    always_comb begin
        state_next    = state_reg;
        emit_idx_next = emit_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        OP_SEND:    state_next = ST_SEND_BUMP;
                        OP_RECEIVE: state_next = s_last ? ST_RECV_BUMP : ST_IDLE;
                        OP_COMPARE: state_next = s_last ? ST_REL : ST_IDLE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEND_BUMP: begin
                state_next    = ST_EMIT;
                emit_idx_next = '0;
            end
            ST_RECV_BUMP: begin
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + FIELD_IDX_W'(1);
                    end
                end
            end
            ST_REL: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            emit_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    `ASSERT_CLK(a_emit_in_range, aclk, aresetn, (state_reg == ST_EMIT) |-> (CNT_W'(emit_idx_reg) < status.entries), "emit index beyond entry count")
    `ASSERT_CLK(a_emit_done, aclk, aresetn, (cmd.load_elem && cmd.emit_last) |=> (state_reg == ST_IDLE), "send run did not finish after last element")
    `ASSERT_NEVER(a_one_load, aclk, aresetn, cmd.load_elem && cmd.load_rel, "two result loads in one cycle")

endmodule

### design/vector_clock_unit_core.sv
// Top level of the vector clock unit: joins the controller and datapath.
// Depends on vcu_pkg, vcu_ctrl and vcu_datapath.
//
// Channel  Direction  Content
// s_       in         one element of an operation (send, receive, compare)
// m_       out        one element of a send run, or one compare relation
// cfg_     in         write of own_index or active_processes
//
// A receive marked last is followed by an increment of the own counter.
// A compare marked last then loads its relation once the result register is free.
// A send increments the own counter, then emits one element per cycle (up to eight),
// each waiting on the single result register while it is occupied.
// Reset is synchronous and clears the counters, flags and configuration.
// The result register holds its transaction while m_tready is low.
module vector_clock_unit_core #(
    parameter int MAX_PROCESSES = 8,
    parameter int COUNTER_BITS  = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // elem_index [2:0], elem_value [34:3], zero padding [39:35]
    input  logic [vcu_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    // operation [1:0]
    input  logic [vcu_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_index [2:0], out_value [34:3], relation [36:35], zero padding [39:37]
    output logic [vcu_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    // result_kind [0]
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [vcu_pkg::CFG_ADDR_W-1:0]     cfg_wr_index,
    input  logic [vcu_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import vcu_pkg::*;

    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [FIELD_IDX_W-1:0] elem_index;
    logic [VALUE_W-1:0]     elem_value;

    assign elem_index = s_tdata[FIELD_IDX_W-1:0];
    assign elem_value = s_tdata[FIELD_IDX_W+VALUE_W-1:FIELD_IDX_W];

    vcu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .s_last   (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    vcu_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .elem_index   (elem_index),
        .elem_value   (elem_value),
        .elem_last    (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

### dv/vector_clock_unit_core_tb.sv
// Self-checking testbench for vector_clock_unit_core: directed and random
// send, receive and compare transactions under several register settings.
// Depends on vcu_pkg and the vector clock unit RTL; nothing else.
module vector_clock_unit_core_tb;
    import vcu_pkg::*;

    localparam int N_PROC        = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int IN_PAD_W      = IN_TDATA_W - FIELD_IDX_W - VALUE_W;

    localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VAL_MAX   = '1;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [FIELD_IDX_W-1:0] idx;
        logic [VALUE_W-1:0]     val;
        logic                   last;
    } vc_item_t;

    typedef struct packed {
        logic                   kind;
        logic [FIELD_IDX_W-1:0] idx;
        logic [VALUE_W-1:0]     val;
        logic                   last;
        logic [REL_W-1:0]       rel;
    } vc_result_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata      = '0;
    logic                   s_tlast      = 1'b0;
    logic [OP_W-1:0]        s_tuser      = '0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;

    vector_clock_unit_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // Expected state of the unit.
    logic [VALUE_W-1:0]     vec_cnt [N_PROC];
    logic [FIELD_IDX_W-1:0] own_sel    = OWN_INDEX_RESET;
    logic [CNT_W-1:0]       active_cnt = ACTIVE_RESET;
    logic                   in_gt_seen = 1'b0;
    logic                   st_gt_seen = 1'b0;

    vc_item_t   stim_q[$];
    vc_result_t results_due[$];

    int n_send = 0, n_receive = 0, n_compare = 0, n_unused = 0;
    int n_settings = 0, n_checked = 0, n_errors = 0, cycle_count = 0;
    int rel_seen [4] = '{0, 0, 0, 0};

    function automatic int unsigned entries_used();
        int unsigned n;
        n = active_cnt;
        if (n == 0) n = 1;
        if (n > N_PROC) n = N_PROC;
        return n;
    endfunction

    function automatic void bump_own_counter();
        if (own_sel < entries_used() && vec_cnt[own_sel] != VAL_MAX) begin
            vec_cnt[own_sel] = vec_cnt[own_sel] + 1'b1;
        end
    endfunction

    function automatic void advance_clock(input vc_item_t it);
        int unsigned n;
        logic        in_range;
        vc_result_t  r;
        n = entries_used();
        in_range = (it.idx < n);
        case (it.op)
            OP_SEND: begin
                n_send++;
                bump_own_counter();
                if (n > RUN_LIMIT) n = RUN_LIMIT;
                for (int i = 0; i < n; i++) begin
                    r.kind = KIND_ELEMENT;
                    r.idx  = FIELD_IDX_W'(i);
                    r.val  = vec_cnt[i];
                    r.last = (i == n - 1);
                    r.rel  = REL_EQUAL;
                    results_due.push_back(r);
                end
            end
            OP_RECEIVE: begin
                n_receive++;
                if (in_range && it.val > vec_cnt[it.idx]) vec_cnt[it.idx] = it.val;
                if (it.last) bump_own_counter();
            end
            OP_COMPARE: begin
                n_compare++;
                if (in_range) begin
                    if (it.val > vec_cnt[it.idx]) in_gt_seen = 1'b1;
                    else if (it.val < vec_cnt[it.idx]) st_gt_seen = 1'b1;
                end
                if (it.last) begin
                    r.kind = KIND_RELATION;
                    r.idx  = '0;
                    r.val  = '0;
                    r.last = 1'b1;
                    if (in_gt_seen && st_gt_seen) r.rel = REL_CONCURRENT;
                    else if (in_gt_seen) r.rel = REL_INCOMING;
                    else if (st_gt_seen) r.rel = REL_STORED;
                    else r.rel = REL_EQUAL;
                    rel_seen[r.rel]++;
                    in_gt_seen = 1'b0;
                    st_gt_seen = 1'b0;
                    results_due.push_back(r);
                end
            end
            default: n_unused++;
        endcase
    endfunction

    // Driver: bursts of random length separated by random gaps when gap_max is nonzero.
    vc_item_t cur_item;
    int       burst_left = 0;
    int       gap_left   = 0;
    int       gap_max    = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_clock(cur_item);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    cur_item = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{IN_PAD_W{1'b0}}, cur_item.val, cur_item.idx};
                    s_tlast  <= cur_item.last;
                    s_tuser  <= cur_item.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        if (gap_max > 0) gap_left = $urandom_range(1, gap_max);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern chosen per phase, plus an occasional long hold-off.
    int rx_mode   = 0;
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_tick   = 0;

    always @(posedge aclk) begin
        rx_tick++;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_tick % 7) < 4);
            endcase
        end
    end

    function automatic void flag_field(input string name, input logic [VALUE_W-1:0] want,
                                       input logic [VALUE_W-1:0] got);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                     n_checked, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_monitor
        vc_result_t got;
        vc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.idx  = m_tdata[FIELD_IDX_W-1:0];
            got.val  = m_tdata[FIELD_IDX_W+VALUE_W-1:FIELD_IDX_W];
            got.last = m_tlast;
            got.rel  = m_tdata[FIELD_IDX_W+VALUE_W+REL_W-1:FIELD_IDX_W+VALUE_W];
            if (results_due.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("Unexpected result transaction: kind %0d index %0d value 0x%0h",
                             got.kind, got.idx, got.val);
                end
            end else begin
                want = results_due.pop_front();
                if (got.kind !== want.kind) flag_field("result_kind", want.kind, got.kind);
                if (got.idx !== want.idx) flag_field("out_index", want.idx, got.idx);
                if (got.val !== want.val) flag_field("out_value", want.val, got.val);
                if (got.last !== want.last) flag_field("out_last", want.last, got.last);
                if (got.rel !== want.rel) flag_field("relation", want.rel, got.rel);
            end
            n_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void add_item(input logic [OP_W-1:0] op, input int unsigned idx,
                                     input logic [VALUE_W-1:0] val, input logic last);
        vc_item_t it;
        it.op   = op;
        it.idx  = FIELD_IDX_W'(idx);
        it.val  = val;
        it.last = last;
        stim_q.push_back(it);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int unsigned idx);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_W'($urandom_range(0, 6));
            4, 5: return vec_cnt[idx];
            6: return vec_cnt[idx] + 1'b1;
            7: return vec_cnt[idx] - 1'b1;
            8: return $urandom();
            default: return $urandom_range(0, 1) ? VAL_MAX : '0;
        endcase
    endfunction

    function automatic void add_vector(input logic [OP_W-1:0] op, input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            add_item(op, i, pick_value(i), i == len - 1);
        end
    endfunction

    // Compare against an exact copy of the stored vector, optionally with one
    // element raised and one lowered. Only valid once the unit has drained.
    function automatic void add_copy_compare(input int up_idx, input int down_idx);
        logic [VALUE_W-1:0] v;
        int unsigned        n;
        n = entries_used();
        for (int unsigned i = 0; i < n; i++) begin
            v = vec_cnt[i];
            if (i == up_idx && v != VAL_MAX) v = v + 1'b1;
            if (i == down_idx && v != '0) v = v - 1'b1;
            add_item(OP_COMPARE, i, v, i == n - 1);
        end
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (stim_q.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] own_val,
                            input logic [CFG_DATA_W-1:0] act_val);
        wait_drained();
        write_reg(CFG_OWN_INDEX, own_val);
        own_sel = own_val[FIELD_IDX_W-1:0];
        write_reg(CFG_ACTIVE_PROCESSES, act_val);
        active_cnt = act_val;
        n_settings++;
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned made;
        int unsigned pick;
        int unsigned len;
        made = 0;
        while (made < n_items) begin
            while (stim_q.size() > 4) @(posedge aclk);
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                add_item(OP_SEND, $urandom_range(0, 7), $urandom(),
                         1'($urandom_range(0, 1)));
                made++;
            end else if (pick < 75) begin
                len = $urandom_range(0, 1) ? entries_used() : $urandom_range(1, N_PROC);
                add_vector(pick < 50 ? OP_RECEIVE : OP_COMPARE, len);
                made += len;
            end else if (pick < 88) begin
                add_item($urandom_range(0, 1) ? OP_RECEIVE : OP_COMPARE,
                         $urandom_range(0, 7), pick_value($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
                made++;
            end else if (pick < 93) begin
                add_item(OP_UNUSED, $urandom_range(0, 7), $urandom(),
                         1'($urandom_range(0, 1)));
            end else begin
                add_item(OP_W'($urandom_range(0, 2)), $urandom_range(0, 7), $urandom(),
                         1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    initial begin
        foreach (vec_cnt[i]) vec_cnt[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset settings first.
        add_item(OP_SEND, 0, '0, 1'b0);
        add_item(OP_RECEIVE, 0, 32'd3, 1'b0);
        add_item(OP_RECEIVE, 1, VAL_MAX, 1'b0);
        add_item(OP_RECEIVE, 7, 32'h8000_0000, 1'b1);
        add_item(OP_UNUSED, 5, $urandom(), 1'b1);
        add_item(OP_SEND, 7, VAL_MAX, 1'b1);

        set_regs(4'd1, 4'd2);
        add_copy_compare(-1, -1);
        add_copy_compare(0, -1);
        add_copy_compare(-1, 1);
        add_copy_compare(0, 1);
        add_item(OP_RECEIVE, 1, VAL_MAX, 1'b1);
        add_item(OP_SEND, 0, '0, 1'b0);

        set_regs(4'd5, 4'd3);
        add_item(OP_SEND, 3, '0, 1'b0);
        add_item(OP_RECEIVE, 6, VAL_MAX, 1'b1);
        add_item(OP_COMPARE, 7, '0, 1'b1);

        set_regs(4'd0, 4'd0);
        add_item(OP_SEND, 0, '0, 1'b0);
        add_item(OP_COMPARE, 0, VAL_MAX, 1'b0);

        // The flag collected above must survive the register write.
        set_regs(4'd7, 4'd15);
        add_item(OP_SEND, 0, '0, 1'b0);
        add_item(OP_COMPARE, 3, vec_cnt[3], 1'b1);

        // Random part.
        gap_max = 0;
        rx_mode = 0;
        set_regs(4'd0, 4'd8);
        random_phase(50);

        gap_max = 4;
        rx_mode = 1;
        set_regs(4'd7, 4'd8);
        hold_req++;
        random_phase(50);

        gap_max = 8;
        rx_mode = 2;
        set_regs(4'd2, 4'd1);
        random_phase(50);

        gap_max = 3;
        rx_mode = 1;
        set_regs(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
        random_phase(50);

        gap_max = 6;
        rx_mode = 2;
        set_regs(CFG_DATA_W'($urandom_range(8, 15)), CFG_DATA_W'($urandom_range(0, 15)));
        random_phase(50);

        wait_drained();
        $display("Covered %0d send, %0d receive, %0d compare and %0d unused-code items",
                 n_send, n_receive, n_compare, n_unused);
        $display("over %0d register settings; %0d results checked, relations %0d/%0d/%0d/%0d",
                 n_settings, n_checked, rel_seen[0], rel_seen[1], rel_seen[2], rel_seen[3]);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
